@@ rtl/rgb_hsl_converter_defines.svh @@
// ----------------------------------------------------------------------------
// rgb hsl converter assertion macros
// shared concurrent assertion forms for the converter rtl
// ----------------------------------------------------------------------------
`ifndef RGB_HSL_CONVERTER_DEFINES_SVH
`define RGB_HSL_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RHC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define RHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg
// types and constants shared by the rgb hsl converter modules
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int unsigned HUE_IN_W = 16;
  localparam int unsigned SL_W     = 13;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned HUE_W    = 13;

  localparam logic [12:0] ONE_Q        = 13'd4096;
  localparam logic [12:0] TURN_UNITS   = 13'd5760;
  localparam logic [9:0]  SECTOR_UNITS = 10'd960;

  // reciprocal multipliers, each followed by a single correction step
  localparam logic [13:0] TURN_RECIP  = 14'd11650;  // 2^26 / 5760
  localparam logic [10:0] SECT_RECIP  = 11'd1092;   // 2^20 / 960
  localparam logic [12:0] LIG_RECIP   = 13'd4112;   // 2^20 / 255
  localparam logic [12:0] DIV15_RECIP = 13'd4369;   // 2^16 / 15

  localparam int unsigned DIV_NUM_W  = 21;
  localparam int unsigned DIV_DEN_W  = 8;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = DIV_NUM_W / DIV_STEPS;

  localparam int unsigned BACK_STAGES = DIV_STAGES;
  localparam int unsigned LIG_STAGE   = 1;
  localparam int unsigned RGB_STAGE   = 5;

  typedef struct packed {
    logic        cmd;
    logic        gray;
    logic [20:0] hnum;
    logic [7:0]  d;
    logic [19:0] snum;
    logic [7:0]  sden;
    logic [8:0]  sum;
    logic [12:0] a;
    logic [12:0] s;
    logic [12:0] l;
    logic [2:0]  sector;
    logic [9:0]  t;
  } mid_t;

  typedef struct packed {
    logic        cmd;
    logic        gray;
    logic [12:0] lig;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } side_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] hue;
    logic [12:0] sat;
    logic [12:0] lig;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/rhc_front.sv @@
// ----------------------------------------------------------------------------
// rhc_front
// two-stage request intake: clamps, hue reduction, rgb classification
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic                           command_i,
  input  logic [7:0]                     in_red_i,
  input  logic [7:0]                     in_green_i,
  input  logic [7:0]                     in_blue_i,
  input  logic [rhc_pkg::HUE_IN_W-1:0]   in_hue_i,
  input  logic [rhc_pkg::SL_W-1:0]       in_saturation_i,
  input  logic [rhc_pkg::SL_W-1:0]       in_lightness_i,
  output logic                           mid_push_o,
  output rhc_pkg::mid_t                  mid_o,
  input  logic                           mid_full_i
);
  import rhc_pkg::*;

  logic        en;
  logic        v1_q, v2_q;
  logic        cmd1_q;
  logic [7:0]  r1_q, g1_q, b1_q, mx1_q, mn1_q;
  logic [12:0] hm1_q, s1_q, l1_q, a1_q;
  mid_t        mid_q, mid_d;

  logic [7:0]  mx, mn;
  logic [29:0] hprod;
  logic [3:0]  hqe;
  logic [16:0] hmul;
  logic [15:0] hsub, hm;
  logic [12:0] s_c, l_c;
  logic [13:0] l2, a14;

  assign en     = !(v2_q && mid_full_i);
  assign full_o = !en;

  // stage one
  always_comb begin
    mx = in_red_i;
    mn = in_red_i;
    if (in_green_i > mx) mx = in_green_i;
    if (in_blue_i > mx)  mx = in_blue_i;
    if (in_green_i < mn) mn = in_green_i;
    if (in_blue_i < mn)  mn = in_blue_i;
    hprod = in_hue_i * TURN_RECIP;
    hqe   = hprod[29:26];
    hmul  = hqe * TURN_UNITS;
    hsub  = in_hue_i - hmul[15:0];
    hm    = (hsub >= {3'b0, TURN_UNITS}) ? hsub - {3'b0, TURN_UNITS} : hsub;
    s_c   = (in_saturation_i > ONE_Q) ? ONE_Q : in_saturation_i;
    l_c   = (in_lightness_i > ONE_Q) ? ONE_Q : in_lightness_i;
    l2    = {l_c, 1'b0};
    a14   = (l2 >= {1'b0, ONE_Q}) ? 14'd8192 - l2 : l2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q <= command_i;
      r1_q   <= in_red_i;
      g1_q   <= in_green_i;
      b1_q   <= in_blue_i;
      mx1_q  <= mx;
      mn1_q  <= mn;
      hm1_q  <= hm[12:0];
      s1_q   <= s_c;
      l1_q   <= l_c;
      a1_q   <= a14[12:0];
      mid_q  <= mid_d;
    end
  end

  // stage two
  logic [7:0]  d;
  logic [10:0] d11, r11, g11, b11, num;
  logic [20:0] n21;
  logic [8:0]  sum9, sden9;
  logic [23:0] sprod;
  logic [2:0]  sqe, sec;
  logic [12:0] smul, srem;

  always_comb begin
    d     = mx1_q - mn1_q;
    d11   = {3'b0, d};
    r11   = {3'b0, r1_q};
    g11   = {3'b0, g1_q};
    b11   = {3'b0, b1_q};
    if (mx1_q == r1_q) begin
      num = (g1_q >= b1_q) ? g11 - b11 : d11 * 11'd6 - (b11 - g11);
    end else if (mx1_q == g1_q) begin
      num = (d11 << 1) + b11 - r11;
    end else begin
      num = (d11 << 2) + r11 - g11;
    end
    n21   = {10'b0, num};
    sum9  = {1'b0, mx1_q} + {1'b0, mn1_q};
    sden9 = (sum9 > 9'd255) ? 9'd510 - sum9 : sum9;
    sprod = hm1_q * SECT_RECIP;
    sqe   = sprod[22:20];
    smul  = sqe * SECTOR_UNITS;
    srem  = hm1_q - smul;
    sec   = sqe;
    if (srem >= {3'b0, SECTOR_UNITS}) begin
      srem = srem - {3'b0, SECTOR_UNITS};
      sec  = sqe + 3'd1;
    end
    mid_d.cmd    = cmd1_q;
    mid_d.gray   = (d == 8'd0);
    mid_d.hnum   = (n21 << 10) - (n21 << 6);
    mid_d.d      = d;
    mid_d.snum   = {d, 12'b0};
    mid_d.sden   = sden9[7:0];
    mid_d.sum    = sum9;
    mid_d.a      = a1_q;
    mid_d.s      = s1_q;
    mid_d.l      = l1_q;
    mid_d.sector = sec;
    mid_d.t      = sec[0] ? SECTOR_UNITS - srem[9:0] : srem[9:0];
  end

  assign mid_push_o = v2_q && !mid_full_i;
  assign mid_o      = mid_q;

endmodule

`default_nettype wire

@@ rtl/rhc_queue.sv @@
// ----------------------------------------------------------------------------
// rhc_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rhc_pkg::mid_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output rhc_pkg::mid_t data_o,
  output logic          empty_o
);
  import rhc_pkg::*;

  mid_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

@@ rtl/rhc_div.sv @@
// ----------------------------------------------------------------------------
// rhc_div
// pipelined restoring divider, a few quotient bits per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rhc_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [rhc_pkg::DIV_DEN_W-1:0] den_i,
  output logic [rhc_pkg::DIV_NUM_W-1:0] quo_o
);
  import rhc_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q [DIV_STAGES];
  logic [DIV_NUM_W-1:0] nq_q  [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_q [DIV_STAGES];
  logic [DIV_DEN_W-1:0] rem_d [DIV_STAGES];
  logic [DIV_NUM_W-1:0] nq_d  [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_d [DIV_STAGES];

  always_comb begin
    logic [DIV_DEN_W:0]   tmp;
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_NUM_W-1:0] nq;
    logic [DIV_DEN_W-1:0] den;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem = '0;
        nq  = num_i;
        den = den_i;
      end else begin
        rem = rem_q[s-1];
        nq  = nq_q[s-1];
        den = den_q[s-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        tmp = {rem, nq[DIV_NUM_W-1]};
        nq  = {nq[DIV_NUM_W-2:0], 1'b0};
        if (tmp >= {1'b0, den}) begin
          tmp   = tmp - {1'b0, den};
          nq[0] = 1'b1;
        end
        rem = tmp[DIV_DEN_W-1:0];
      end
      rem_d[s] = rem;
      nq_d[s]  = nq;
      den_d[s] = den;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_q[s] <= rem_d[s];
        nq_q[s]  <= nq_d[s];
        den_q[s] <= den_d[s];
      end
    end
  end

  assign quo_o = nq_q[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/rhc_back.sv @@
// ----------------------------------------------------------------------------
// rhc_back
// execution pipeline: hue and saturation dividers, rgb channel math, result queue
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mid_empty_i,
  input  rhc_pkg::mid_t mid_i,
  output logic          mid_pop_o,
  output logic          out_empty_o,
  input  logic          out_pop_i,
  output rhc_pkg::out_t out_o
);
  import rhc_pkg::*;

  logic  en;
  logic  ofull;
  logic  v_q    [BACK_STAGES];
  side_t side_q [BACK_STAGES];
  side_t side_d [BACK_STAGES];
  logic [DIV_NUM_W-1:0] hq, sq;

  assign en        = !(v_q[BACK_STAGES-1] && ofull);
  assign mid_pop_o = en && !mid_empty_i;

  rhc_div u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mid_i.hnum),
    .den_i (mid_i.d),
    .quo_o (hq)
  );

  rhc_div u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({1'b0, mid_i.snum}),
    .den_i (mid_i.sden),
    .quo_o (sq)
  );

  // hsl to rgb and lightness side path
  logic [25:0] cw0_q;
  logic [9:0]  t0_q;
  logic [12:0] l0_q;
  logic [2:0]  sec0_q, sec1_q, sec2_q, sec3_q, sec4_q;
  logic [11:0] nl0_q;
  logic [3:0]  lqe0_q;
  logic [35:0] ct1_q, x2_q;
  logic [25:0] bb1_q, vc1_q;
  logic [7:0]  cch2_q, zch2_q, cch3_q, zch3_q, cch4_q, zch4_q;
  logic [12:0] y3_q, y4_q;
  logic [8:0]  qe4_q;

  logic [24:0] lprod;
  logic [25:0] l13;
  logic [11:0] lmul, lr;
  logic [4:0]  lq;
  logic [12:0] lig;
  logic [35:0] bb36;
  logic [33:0] cv, zv;
  logic [43:0] xv;
  logic [25:0] yp;
  logic [12:0] q15, yr;
  logic [9:0]  xq;
  logic [7:0]  xch, c, x, z;

  always_comb begin
    lprod = {mid_i.sum, 3'b0} * LIG_RECIP;
    l13   = {l0_q, 13'b0};
    lmul  = lqe0_q * 8'd255;
    lr    = nl0_q - lmul;
    lq    = (lr >= 12'd255) ? {1'b0, lqe0_q} + 5'd1 : {1'b0, lqe0_q};
    lig   = {1'b0, nl0_q} + {8'b0, lq};
    bb36  = {10'b0, bb1_q};
    cv    = ({8'b0, vc1_q} << 8) - {8'b0, vc1_q};
    zv    = ({8'b0, bb1_q} << 8) - {8'b0, bb1_q};
    xv    = ({8'b0, x2_q} << 8) - {8'b0, x2_q};
    yp    = y3_q * DIV15_RECIP;
    q15   = {4'b0, qe4_q} * 13'd15;
    yr    = y4_q - q15;
    xq    = (yr >= 13'd15) ? {1'b0, qe4_q} + 10'd1 : {1'b0, qe4_q};
    xch   = (xq > 10'd255) ? 8'd255 : xq[7:0];
    c     = cch4_q;
    x     = xch;
    z     = zch4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cw0_q  <= mid_i.a * mid_i.s;
      t0_q   <= mid_i.t;
      l0_q   <= mid_i.l;
      sec0_q <= mid_i.sector;
      nl0_q  <= {mid_i.sum, 3'b0};
      lqe0_q <= lprod[23:20];
      ct1_q  <= cw0_q * t0_q;
      bb1_q  <= l13 - cw0_q;
      vc1_q  <= l13 + cw0_q;
      sec1_q <= sec0_q;
      x2_q   <= (ct1_q << 1) + (bb36 << 10) - (bb36 << 6);
      cch2_q <= (cv[33:25] > 9'd255) ? 8'd255 : cv[32:25];
      zch2_q <= (zv[33:25] > 9'd255) ? 8'd255 : zv[32:25];
      sec2_q <= sec1_q;
      y3_q   <= xv[43:31];
      cch3_q <= cch2_q;
      zch3_q <= zch2_q;
      sec3_q <= sec2_q;
      qe4_q  <= yp[24:16];
      y4_q   <= y3_q;
      cch4_q <= cch3_q;
      zch4_q <= zch3_q;
      sec4_q <= sec3_q;
    end
  end

  always_comb begin
    side_d[0].cmd   = mid_i.cmd;
    side_d[0].gray  = mid_i.gray;
    side_d[0].lig   = '0;
    side_d[0].red   = '0;
    side_d[0].green = '0;
    side_d[0].blue  = '0;
    for (int i = 1; i < BACK_STAGES; i++) begin
      side_d[i] = side_q[i-1];
    end
    side_d[LIG_STAGE].lig = side_q[LIG_STAGE-1].cmd ? 13'd0 : lig;
    if (side_q[RGB_STAGE-1].cmd) begin
      unique case (sec4_q)
        3'd0:    {side_d[RGB_STAGE].red, side_d[RGB_STAGE].green, side_d[RGB_STAGE].blue} = {c, x, z};
        3'd1:    {side_d[RGB_STAGE].red, side_d[RGB_STAGE].green, side_d[RGB_STAGE].blue} = {x, c, z};
        3'd2:    {side_d[RGB_STAGE].red, side_d[RGB_STAGE].green, side_d[RGB_STAGE].blue} = {z, c, x};
        3'd3:    {side_d[RGB_STAGE].red, side_d[RGB_STAGE].green, side_d[RGB_STAGE].blue} = {z, x, c};
        3'd4:    {side_d[RGB_STAGE].red, side_d[RGB_STAGE].green, side_d[RGB_STAGE].blue} = {x, z, c};
        default: {side_d[RGB_STAGE].red, side_d[RGB_STAGE].green, side_d[RGB_STAGE].blue} = {c, z, x};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BACK_STAGES; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= mid_pop_o;
      for (int i = 1; i < BACK_STAGES; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < BACK_STAGES; i++) side_q[i] <= side_d[i];
    end
  end

  // result assembly
  side_t fin;
  out_t  res;

  always_comb begin
    fin       = side_q[BACK_STAGES-1];
    res.red   = fin.red;
    res.green = fin.green;
    res.blue  = fin.blue;
    res.lig   = fin.lig;
    if (fin.cmd || fin.gray) begin
      res.hue = '0;
      res.sat = '0;
    end else begin
      res.hue = hq[12:0];
      res.sat = (sq > {8'b0, ONE_Q}) ? ONE_Q : sq[12:0];
    end
  end

  // result queue
  out_t       omem_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q;
  logic       opush, opop;

  assign ofull       = (ocnt_q == 2'd2);
  assign out_empty_o = (ocnt_q == 2'd0);
  assign opush       = en && v_q[BACK_STAGES-1];
  assign opop        = out_pop_i && !out_empty_o;
  assign out_o       = omem_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) owr_q <= !owr_q;
      if (opop)  ord_q <= !ord_q;
      ocnt_q <= ocnt_q + {1'b0, opush} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) omem_q[owr_q] <= res;
  end

endmodule

`default_nettype wire

@@ rtl/rgb_hsl_converter.sv @@
// path: front stages, then the mid queue, then the back stages, then the result queue
// throughput: one request per cycle while full is low; the divider pipes take 3 bits per stage
// reset: rst_ni low clears all valid bits and queue counters, no results pending
// ----------------------------------------------------------------------------
// rgb_hsl_converter
// converts rgb to hsl or hsl to rgb per request, chosen by command
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_hsl_converter_defines.svh"

module rgb_hsl_converter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request side
  input  logic                         push,
  output logic                         full,
  input  logic                         command_i,
  input  logic [7:0]                   in_red_i,
  input  logic [7:0]                   in_green_i,
  input  logic [7:0]                   in_blue_i,
  input  logic [rhc_pkg::HUE_IN_W-1:0] in_hue_i,
  input  logic [rhc_pkg::SL_W-1:0]     in_saturation_i,
  input  logic [rhc_pkg::SL_W-1:0]     in_lightness_i,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_red_o,
  output logic [7:0]                   out_green_o,
  output logic [7:0]                   out_blue_o,
  output logic [rhc_pkg::HUE_W-1:0]    out_hue_o,
  output logic [rhc_pkg::SL_W-1:0]     out_saturation_o,
  output logic [rhc_pkg::SL_W-1:0]     out_lightness_o
);
  import rhc_pkg::*;

  // front to queue
  logic mid_push, mid_full, mid_pop, mid_empty;
  mid_t mid_in, mid_out;
  out_t res;

  // front: clamps, hue wrap, max/min, sector and numerators
  rhc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .command_i       (command_i),
    .in_red_i        (in_red_i),
    .in_green_i      (in_green_i),
    .in_blue_i       (in_blue_i),
    .in_hue_i        (in_hue_i),
    .in_saturation_i (in_saturation_i),
    .in_lightness_i  (in_lightness_i),
    .mid_push_o      (mid_push),
    .mid_o           (mid_in),
    .mid_full_i      (mid_full)
  );

  // short queue so front and back stall independently
  rhc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  // back: divider pipes, channel math, result queue
  rhc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_i       (mid_out),
    .mid_pop_o   (mid_pop),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .out_o       (res)
  );

  assign out_red_o        = res.red;
  assign out_green_o      = res.green;
  assign out_blue_o       = res.blue;
  assign out_hue_o        = res.hue;
  assign out_saturation_o = res.sat;
  assign out_lightness_o  = res.lig;

  // an hsl result never carries rgb fields
  `RHC_ASSERT_IMPL(a_fields_exclusive, !empty && out_hue_o != '0, out_red_o == '0 && out_green_o == '0 && out_blue_o == '0)
  // hue stays within one turn
  `RHC_ASSERT_IMPL(a_hue_range, !empty, out_hue_o < TURN_UNITS)
  // saturation and lightness never exceed one
  `RHC_ASSERT_IMPL(a_sl_range, !empty, out_saturation_o <= ONE_Q && out_lightness_o <= ONE_Q)
  // a waiting result stays put while not popped
  `RHC_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(out_hue_o) && $stable(out_red_o))

endmodule

`default_nettype wire
